// ===== design/nbct_pkg.sv =====
package nbct_pkg;

   localparam int MAX_COLUMNS_DEF = 16;
   localparam int MAX_CLASSES_DEF = 8;
   localparam int MAX_VALUES_DEF  = 1024;
   localparam int COUNT_WIDTH_DEF = 32;

   localparam int KIND_W   = 2;
   localparam int SVAL_W   = 10;
   localparam int CLS_W    = 3;
   localparam int FEAT_W   = 4;
   localparam int PROB_W   = 17;
   localparam int RAW_W    = 32;
   localparam int STATUS_W = 2;

   localparam logic [KIND_W-1:0] KIND_SAMPLE = 2'd0;
   localparam logic [KIND_W-1:0] KIND_PRIOR  = 2'd1;
   localparam logic [KIND_W-1:0] KIND_COND   = 2'd2;
   localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd3;

   localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
   localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;

   localparam int CFG_COLUMNS = 0;
   localparam int CFG_CLASSES = 1;
   localparam int CFG_VALUES  = 2;

   localparam logic [4:0]  COLUMNS_RESET = 5'd16;
   localparam logic [3:0]  CLASSES_RESET = 4'd8;
   localparam logic [10:0] VALUES_RESET  = 11'd1000;

   localparam int Q_BITS = 16;

   // divider handshake between sequencer and divider
   typedef struct packed {
      logic        start;
      logic [31:0] num;
      logic [31:0] den;
   } div_req_type;

   typedef struct packed {
      logic        done;
      logic [PROB_W-1:0] quot;
   } div_rsp_type;

endpackage

// ===== design/nbct_if.sv =====
interface nbct_req_if;
   logic        valid;
   logic        ready;
   logic [nbct_pkg::KIND_W-1:0] kind;
   logic [nbct_pkg::SVAL_W-1:0] sample_value;
   logic [nbct_pkg::CLS_W-1:0]  class_index;
   logic [nbct_pkg::FEAT_W-1:0] feature_index;
   logic [nbct_pkg::SVAL_W-1:0] query_value;
   modport source (output valid, kind, sample_value, class_index, feature_index,
                   query_value, input ready);
   modport sink   (input valid, kind, sample_value, class_index, feature_index,
                   query_value, output ready);
endinterface

interface nbct_rsp_if;
   logic        valid;
   logic        ready;
   logic [nbct_pkg::PROB_W-1:0]   probability;
   logic [nbct_pkg::RAW_W-1:0]    raw_count;
   logic [nbct_pkg::STATUS_W-1:0] status;
   modport source (output valid, probability, raw_count, status, input ready);
   modport sink   (input valid, probability, raw_count, status, output ready);
endinterface

// ===== design/nbct_divider.sv =====
// Restoring divider: floor(num * 2^16 / den), limited to 2^16, one bit a cycle.
module nbct_divider (
   input  logic                  clock,
   input  logic                  reset,
   input  nbct_pkg::div_req_type req,
   output nbct_pkg::div_rsp_type rsp
);
   localparam int NW = 32 + nbct_pkg::Q_BITS;

   logic [NW-1:0] num_ff, num_in;
   logic [32:0]   rem_ff, rem_in;
   logic [31:0]   den_ff, den_in;
   logic [NW-1:0] quo_ff, quo_in;
   logic [5:0]    cnt_ff, cnt_in;
   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [32:0]   trial;
   logic [32:0]   diff;

   // shift one numerator bit into the remainder and try subtracting
   always_comb begin
      trial   = {rem_ff[31:0], num_ff[NW-1]};
      diff    = trial - {1'b0, den_ff};
      num_in  = num_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      quo_in  = quo_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (req.start) begin
         num_in  = {req.num, {nbct_pkg::Q_BITS{1'b0}}};
         den_in  = req.den;
         rem_in  = '0;
         quo_in  = '0;
         cnt_in  = 6'(NW);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         num_in = {num_ff[NW-2:0], 1'b0};
         if (!diff[32]) begin
            rem_in = diff;
            quo_in = {quo_ff[NW-2:0], 1'b1};
         end else begin
            rem_in = trial;
            quo_in = {quo_ff[NW-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 6'd1;
         if (cnt_ff == 6'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      num_ff <= num_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
      quo_ff <= quo_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   // clamp to one
   assign rsp.done = done_ff;
   assign rsp.quot = (quo_ff > NW'(1 << nbct_pkg::Q_BITS)) ?
                     nbct_pkg::PROB_W'(1 << nbct_pkg::Q_BITS) :
                     quo_ff[nbct_pkg::PROB_W-1:0];

`ifndef ASSERT_OFF
   a_done_single: assert property (@(posedge clock) disable iff (reset)
      done_ff |=> !done_ff) else $error("divider done held");
   a_busy_start: assert property (@(posedge clock) disable iff (reset)
      req.start |=> busy_ff) else $error("divider did not start");
   a_quot_bound: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> rsp.quot <= nbct_pkg::PROB_W'(1 << nbct_pkg::Q_BITS))
      else $error("quotient over one");
`endif
endmodule

// ===== design/naive_bayes_count_trainer.sv =====
// Channel | Dir | Handshake     | Word
// req     | in  | valid/ready   | kind, sample_value, class_index, feature_index, query_value
// rsp     | out | valid/ready   | probability, raw_count, status
// csr     | in  | APB, pready=1 | column_count @0, class_count @4, value_count @8
// Steps: a feature column passes through S_SWR; a label walks S_FRD, S_FWAIT, S_FWR per counted
// feature column (read, write of the count memory) and S_FRD alone per skipped one. A query result
// waits on the one-bit-a-cycle divider unless it is out of range or its denominator is zero. After reset and
// after a clear item, a sweep writes zero to all MAX_CLASSES*(MAX_COLUMNS-1)*MAX_VALUES words of the
// count memory; req.ready is low. Reset is synchronous, active high.
// A stalled result holds the block until taken.
module naive_bayes_count_trainer #(
   parameter int MAX_COLUMNS = nbct_pkg::MAX_COLUMNS_DEF,
   parameter int MAX_CLASSES = nbct_pkg::MAX_CLASSES_DEF,
   parameter int MAX_VALUES  = nbct_pkg::MAX_VALUES_DEF,
   parameter int COUNT_WIDTH = nbct_pkg::COUNT_WIDTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   nbct_req_if.sink    req,
   nbct_rsp_if.source  rsp,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   localparam int FSLOTS = MAX_COLUMNS - 1;
   localparam int DEPTH  = MAX_CLASSES * FSLOTS * MAX_VALUES;
   localparam int AW     = $clog2(DEPTH);
   localparam int CW     = $clog2(MAX_COLUMNS);
   localparam int KW     = $clog2(MAX_CLASSES);
   localparam int VW     = $clog2(MAX_VALUES);
   localparam int PW     = CW + 1;
   localparam logic [COUNT_WIDTH-1:0] CMAX = '1;

   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_SWEEP  = 4'd1;
   localparam logic [3:0] S_FRD    = 4'd2;
   localparam logic [3:0] S_FWAIT  = 4'd3;
   localparam logic [3:0] S_FWR    = 4'd4;
   localparam logic [3:0] S_QRD    = 4'd5;
   localparam logic [3:0] S_QWAIT  = 4'd6;
   localparam logic [3:0] S_QDIV   = 4'd7;
   localparam logic [3:0] S_QBUSY  = 4'd8;
   localparam logic [3:0] S_SWR    = 4'd9;

   // configuration registers
   logic [4:0]  ccols_ff;
   logic [3:0]  ccls_ff;
   logic [10:0] cvals_ff;
   logic        wr_en;

   assign csr_pready = 1'b1;
   assign wr_en = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         ccols_ff <= nbct_pkg::COLUMNS_RESET;
         ccls_ff  <= nbct_pkg::CLASSES_RESET;
         cvals_ff <= nbct_pkg::VALUES_RESET;
      end else if (wr_en) begin
         if (csr_paddr[3:2] == 2'(nbct_pkg::CFG_COLUMNS)) ccols_ff <= csr_pwdata[4:0];
         if (csr_paddr[3:2] == 2'(nbct_pkg::CFG_CLASSES)) ccls_ff  <= csr_pwdata[3:0];
         if (csr_paddr[3:2] == 2'(nbct_pkg::CFG_VALUES))  cvals_ff <= csr_pwdata[10:0];
      end
   end

   always_comb begin
      unique case (csr_paddr[3:2])
         2'(nbct_pkg::CFG_COLUMNS): csr_prdata = {27'd0, ccols_ff};
         2'(nbct_pkg::CFG_CLASSES): csr_prdata = {28'd0, ccls_ff};
         2'(nbct_pkg::CFG_VALUES):  csr_prdata = {21'd0, cvals_ff};
         default:                   csr_prdata = '0;
      endcase
   end

   // effective limits
   logic [6:0]  eff_cols;
   logic [6:0]  eff_cls;
   logic [12:0] eff_vals;
   always_comb begin
      eff_cols = {2'd0, ccols_ff};
      if (eff_cols < 7'd2) eff_cols = 7'd2;
      if (eff_cols > 7'(MAX_COLUMNS)) eff_cols = 7'(MAX_COLUMNS);
      eff_cls = (ccls_ff > 4'(MAX_CLASSES) && MAX_CLASSES < 16) ? 7'(MAX_CLASSES)
                                                                : {3'd0, ccls_ff};
      if ({3'd0, ccls_ff} > 7'(MAX_CLASSES)) eff_cls = 7'(MAX_CLASSES);
      eff_vals = ({2'd0, cvals_ff} > 13'(MAX_VALUES)) ? 13'(MAX_VALUES) : {2'd0, cvals_ff};
   end

   // stores
   logic [9:0]             rowbuf [MAX_COLUMNS];
   logic [COUNT_WIDTH-1:0] mem [DEPTH];
   logic [COUNT_WIDTH-1:0] mem_q;
   logic [AW-1:0]          mem_ra, mem_wa;
   logic                   mem_we;
   logic [COUNT_WIDTH-1:0] mem_wd;
   logic [COUNT_WIDTH-1:0] rows_ff, rows_in;
   logic [COUNT_WIDTH-1:0] tot_ff [MAX_CLASSES];

   always_ff @(posedge clock) begin
      if (mem_we) mem[mem_wa] <= mem_wd;
      mem_q <= mem[mem_ra];
   end

   logic [3:0]  st_ff, st_in;
   logic [PW-1:0] pos_ff, pos_in;
   logic [PW-1:0] j_ff, j_in;
   logic [KW-1:0] lab_ff, lab_in;
   logic [AW-1:0] sw_ff, sw_in;
   logic [AW-1:0] addr_ff, addr_in;
   logic [COUNT_WIDTH-1:0] qraw_ff, qraw_in, qden_ff, qden_in;
   logic          ov_ff, ov_in;
   logic [nbct_pkg::PROB_W-1:0]   op_ff, op_in;
   logic [nbct_pkg::RAW_W-1:0]    or_ff, or_in;
   logic [nbct_pkg::STATUS_W-1:0] os_ff, os_in;
   logic          buf_we, tot_we, clr_tot;
   logic [KW-1:0] tot_idx;
   logic [9:0]    fv;
   logic          acc;
   nbct_pkg::div_req_type dreq;
   nbct_pkg::div_rsp_type drsp;

   assign req.ready = (st_ff == S_IDLE);
   assign acc = req.valid && req.ready;
   assign fv  = rowbuf[j_ff[CW-1:0]];

   function automatic logic [AW-1:0] slot(input logic [KW-1:0] c,
                                          input logic [CW-1:0] f,
                                          input logic [VW-1:0] v);
      slot = AW'((32'(c) * 32'(FSLOTS) + 32'(f)) * 32'(MAX_VALUES) + 32'(v));
   endfunction

   // sequencer
   always_comb begin
      st_in   = st_ff;
      pos_in  = pos_ff;
      j_in    = j_ff;
      lab_in  = lab_ff;
      sw_in   = sw_ff;
      addr_in = addr_ff;
      qraw_in = qraw_ff;
      qden_in = qden_ff;
      rows_in = rows_ff;
      ov_in   = ov_ff;
      op_in   = op_ff;
      or_in   = or_ff;
      os_in   = os_ff;
      buf_we  = 1'b0;
      tot_we  = 1'b0;
      clr_tot = 1'b0;
      tot_idx = lab_ff;
      mem_we  = 1'b0;
      mem_wa  = addr_ff;
      mem_wd  = '0;
      mem_ra  = addr_ff;
      dreq.start = 1'b0;
      dreq.num   = 32'(qraw_ff);
      dreq.den   = 32'(qden_ff);
      if (ov_ff && rsp.ready) ov_in = 1'b0;
      unique case (st_ff)
         S_IDLE: if (acc) begin
            unique case (req.kind)
               nbct_pkg::KIND_SAMPLE: begin
                  if (7'(pos_ff) < eff_cols - 7'd1) begin
                     buf_we = 1'b1;
                     pos_in = pos_ff + PW'(1);
                     st_in  = S_SWR;
                  end else begin
                     pos_in = '0;
                     st_in  = S_SWR;
                     if ({{(32-10){1'b0}}, req.sample_value} < 32'(eff_cls)) begin
                        lab_in  = KW'(req.sample_value);
                        rows_in = (rows_ff == CMAX) ? CMAX : rows_ff + 1'b1;
                        tot_we  = 1'b1;
                        tot_idx = KW'(req.sample_value);
                        j_in    = '0;
                        st_in   = S_FRD;
                     end
                  end
               end
               nbct_pkg::KIND_CLEAR: begin
                  pos_in  = '0;
                  rows_in = '0;
                  clr_tot = 1'b1;
                  sw_in   = '0;
                  st_in   = S_SWEEP;
               end
               default: begin
                  if (32'(req.class_index) >= 32'(eff_cls) ||
                      (req.kind == nbct_pkg::KIND_COND &&
                       (7'(req.feature_index) >= eff_cols - 7'd1 ||
                        13'(req.query_value) >= eff_vals))) begin
                     op_in = '0;
                     or_in = '0;
                     os_in = nbct_pkg::ST_RANGE;
                     ov_in = 1'b1;
                     st_in = S_QBUSY;
                  end else if (req.kind == nbct_pkg::KIND_PRIOR) begin
                     qraw_in = tot_ff[KW'(req.class_index)];
                     qden_in = rows_ff;
                     st_in   = S_QDIV;
                  end else begin
                     qden_in = tot_ff[KW'(req.class_index)];
                     addr_in = slot(KW'(req.class_index),
                                    CW'(req.feature_index),
                                    VW'(req.query_value));
                     st_in   = S_QRD;
                  end
               end
            endcase
         end
         S_SWR: st_in = S_IDLE;
         S_SWEEP: begin
            mem_we = 1'b1;
            mem_wa = sw_ff;
            sw_in  = sw_ff + AW'(1);
            if (sw_ff == AW'(DEPTH - 1)) st_in = S_IDLE;
         end
         S_FRD: begin
            if (7'(j_ff) >= eff_cols - 7'd1) begin
               st_in = S_IDLE;
            end else if (13'(fv) >= eff_vals) begin
               j_in = j_ff + PW'(1);
            end else begin
               addr_in = slot(lab_ff, j_ff[CW-1:0], VW'(fv));
               st_in   = S_FWAIT;
            end
         end
         S_FWAIT: st_in = S_FWR;
         S_FWR: begin
            mem_we = 1'b1;
            mem_wd = (mem_q == CMAX) ? CMAX : mem_q + 1'b1;
            j_in   = j_ff + PW'(1);
            st_in  = S_FRD;
         end
         S_QRD: st_in = S_QWAIT;
         S_QWAIT: begin
            qraw_in = mem_q;
            st_in   = S_QDIV;
         end
         S_QDIV: begin
            if (qden_ff == '0) begin
               op_in = '0;
               or_in = 32'(qraw_ff);
               os_in = nbct_pkg::ST_EMPTY;
               ov_in = 1'b1;
               st_in = S_QBUSY;
            end else begin
               dreq.start = 1'b1;
               st_in = S_QBUSY;
            end
         end
         S_QBUSY: begin
            if (drsp.done) begin
               op_in = drsp.quot;
               or_in = 32'(qraw_ff);
               os_in = nbct_pkg::ST_OK;
               ov_in = 1'b1;
            end else if (ov_ff && rsp.ready) begin
               st_in = S_IDLE;
            end
         end
         default: st_in = S_IDLE;
      endcase
   end

   // registers
   always_ff @(posedge clock) begin
      if (buf_we) rowbuf[pos_ff[CW-1:0]] <= req.sample_value;
      addr_ff <= addr_in;
      lab_ff  <= lab_in;
      qraw_ff <= qraw_in;
      qden_ff <= qden_in;
      op_ff   <= op_in;
      or_ff   <= or_in;
      os_ff   <= os_in;
      if (reset) begin
         st_ff   <= S_SWEEP;
         sw_ff   <= '0;
         pos_ff  <= '0;
         j_ff    <= '0;
         rows_ff <= '0;
         ov_ff   <= 1'b0;
         for (int i = 0; i < MAX_CLASSES; i++) tot_ff[i] <= '0;
      end else begin
         st_ff   <= st_in;
         sw_ff   <= sw_in;
         pos_ff  <= pos_in;
         j_ff    <= j_in;
         rows_ff <= rows_in;
         ov_ff   <= ov_in;
         if (clr_tot) begin
            for (int i = 0; i < MAX_CLASSES; i++) tot_ff[i] <= '0;
         end else if (tot_we) begin
            tot_ff[tot_idx] <= (tot_ff[tot_idx] == CMAX) ? CMAX : tot_ff[tot_idx] + 1'b1;
         end
      end
   end

   nbct_divider u_div (
      .clock (clock),
      .reset (reset),
      .req   (dreq),
      .rsp   (drsp)
   );

   assign rsp.valid       = ov_ff;
   assign rsp.probability = op_ff;
   assign rsp.raw_count   = 32'(or_ff);
   assign rsp.status      = os_ff;

`ifndef ASSERT_OFF
   a_busy_noready: assert property (@(posedge clock) disable iff (reset)
      ov_ff |-> !req.ready) else $error("ready while result pending");
   a_status_empty: assert property (@(posedge clock) disable iff (reset)
      (ov_ff && rsp.status == nbct_pkg::ST_EMPTY) |-> rsp.probability == '0)
      else $error("empty status with probability");
   a_range_zero: assert property (@(posedge clock) disable iff (reset)
      (ov_ff && rsp.status == nbct_pkg::ST_RANGE) |-> rsp.raw_count == '0)
      else $error("range status with count");
   a_pos_bound: assert property (@(posedge clock) disable iff (reset)
      7'(pos_ff) < 7'(MAX_COLUMNS)) else $error("column position overrun");
`endif
endmodule

// ===== verif/tb_naive_bayes_count_trainer.sv =====
module tb_naive_bayes_count_trainer;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int WATCH_LIMIT = 500000;
   localparam int SETTLE      = 120;
   localparam int LONG_HOLD   = 400;

   typedef struct {
      logic [nbct_pkg::KIND_W-1:0]   kind;
      logic [nbct_pkg::SVAL_W-1:0]   sval;
      logic [nbct_pkg::CLS_W-1:0]    cls;
      logic [nbct_pkg::FEAT_W-1:0]   feat;
      logic [nbct_pkg::SVAL_W-1:0]   qval;
   } req_word_type;

   typedef struct {
      logic [nbct_pkg::PROB_W-1:0]   prob;
      logic [nbct_pkg::RAW_W-1:0]    raw;
      logic [nbct_pkg::STATUS_W-1:0] status;
   } answer_type;

   typedef struct {
      logic [nbct_pkg::KIND_W-1:0]   kind;
      int                            sval;
      int                            cls;
      int                            feat;
      int                            qval;
      bit                            typed;
      int                            prob;
      longint                        raw;
      logic [nbct_pkg::STATUS_W-1:0] status;
   } dir_row_type;

   logic clock = 0;
   logic reset = 1;
   logic        csr_psel = 0, csr_penable = 0, csr_pwrite = 0;
   logic [3:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   nbct_req_if req_if();
   nbct_rsp_if rsp_if();

   naive_bayes_count_trainer u_top (
      .clock(clock), .reset(reset), .req(req_if), .rsp(rsp_if),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   always #4 clock = ~clock;

   // model of the trainer
   logic [4:0]  cfg_cols;
   logic [3:0]  cfg_cls;
   logic [10:0] cfg_vals;
   logic [9:0]  row_buf [16];
   int unsigned row_pos;
   int unsigned rows_total;
   int unsigned class_tot [8];
   int unsigned triple_cnt [int];

   answer_type answers_due [$];
   int  errors = 0;
   int  words_sent = 0;
   int  answers_seen = 0;
   int  phases_run = 0;
   bit  quiet = 0;
   bit  hold_req = 0;
   int  idle_cycles = 0;

   function automatic int eff_cols();
      if (cfg_cols < 2) return 2;
      if (cfg_cols > 16) return 16;
      return int'(cfg_cols);
   endfunction

   function automatic int eff_cls();
      return (cfg_cls > 8) ? 8 : int'(cfg_cls);
   endfunction

   function automatic int eff_vals();
      return (cfg_vals > 1024) ? 1024 : int'(cfg_vals);
   endfunction

   function automatic int triple_key(int c, int f, int v);
      return (c * 15 + f) * 1024 + v;
   endfunction

   function automatic int unsigned bump(int unsigned x);
      return (x == 32'hFFFF_FFFF) ? x : x + 1;
   endfunction

   function automatic logic [nbct_pkg::PROB_W-1:0] q16(int unsigned num, int unsigned den);
      longint unsigned q;
      q = ({32'd0, num} << 16) / den;
      return (q > 65536) ? 17'd65536 : q[nbct_pkg::PROB_W-1:0];
   endfunction

   function automatic void wipe_model();
      row_pos = 0;
      rows_total = 0;
      foreach (class_tot[i]) class_tot[i] = 0;
      triple_cnt.delete();
   endfunction

   // apply one word to the model; returns 1 when an answer is due
   function automatic bit train_or_answer(req_word_type w, output answer_type a);
      int lc, k;
      a = '{default: '0};
      case (w.kind)
         nbct_pkg::KIND_SAMPLE: begin
            lc = eff_cols() - 1;
            if (row_pos < lc) begin
               row_buf[row_pos] = w.sval;
               row_pos++;
               return 0;
            end
            row_pos = 0;
            if (w.sval >= eff_cls()) return 0;
            rows_total = bump(rows_total);
            class_tot[w.sval] = bump(class_tot[w.sval]);
            for (int j = 0; j < lc; j++) begin
               if (row_buf[j] < eff_vals()) begin
                  k = triple_key(int'(w.sval), j, int'(row_buf[j]));
                  triple_cnt[k] = bump(triple_cnt.exists(k) ? triple_cnt[k] : 0);
               end
            end
            return 0;
         end
         nbct_pkg::KIND_CLEAR: begin
            wipe_model();
            return 0;
         end
         nbct_pkg::KIND_PRIOR: begin
            if (w.cls >= eff_cls()) a.status = nbct_pkg::ST_RANGE;
            else begin
               a.raw = class_tot[w.cls];
               if (rows_total == 0) a.status = nbct_pkg::ST_EMPTY;
               else a.prob = q16(a.raw, rows_total);
            end
            return 1;
         end
         default: begin
            if (w.cls >= eff_cls() || w.feat >= eff_cols() - 1 || w.qval >= eff_vals())
               a.status = nbct_pkg::ST_RANGE;
            else begin
               k = triple_key(int'(w.cls), int'(w.feat), int'(w.qval));
               a.raw = triple_cnt.exists(k) ? triple_cnt[k] : 0;
               if (class_tot[w.cls] == 0) a.status = nbct_pkg::ST_EMPTY;
               else a.prob = q16(a.raw, class_tot[w.cls]);
            end
            return 1;
         end
      endcase
   endfunction

   task automatic report(string what, longint got, longint want);
      $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
      errors++;
   endtask

   // drive one word, wait for the handshake, log what it should produce
   task automatic send_word(req_word_type w, bit typed = 0,
                            answer_type typed_ans = '{default: '0});
      answer_type a;
      bit due;
      @(negedge clock);
      if (!quiet && $urandom_range(0, 4) == 0) begin
         req_if.valid = 0;
         repeat ($urandom_range(1, 15)) @(negedge clock);
      end
      req_if.kind          = w.kind;
      req_if.sample_value  = w.sval;
      req_if.class_index   = w.cls;
      req_if.feature_index = w.feat;
      req_if.query_value   = w.qval;
      req_if.valid         = 1;
      forever begin
         @(posedge clock);
         if (req_if.ready) break;
      end
      words_sent++;
      due = train_or_answer(w, a);
      if (due) answers_due.push_back(typed ? typed_ans : a);
   endtask

   // wait for every answer and for the block to go idle
   task automatic drain();
      @(negedge clock);
      req_if.valid = 0;
      while (answers_due.size() != 0 || !req_if.ready) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic csr_write(int idx, logic [31:0] data, int width);
      logic [31:0] mask;
      mask = (32'd1 << width) - 1;
      @(negedge clock);
      csr_psel = 1; csr_penable = 0; csr_pwrite = 1;
      csr_paddr = 4'(4 * idx); csr_pwdata = data;
      @(negedge clock);
      csr_penable = 1;
      @(negedge clock);
      csr_pwrite = 0; csr_penable = 0;
      @(negedge clock);
      csr_penable = 1;
      @(posedge clock);
      if ((csr_prdata & mask) !== (data & mask))
         report($sformatf("csr readback %0d", idx), csr_prdata, data & mask);
      @(negedge clock);
      csr_psel = 0; csr_penable = 0;
      case (idx)
         nbct_pkg::CFG_COLUMNS: cfg_cols = data[4:0];
         nbct_pkg::CFG_CLASSES: cfg_cls  = data[3:0];
         default:               cfg_vals = data[10:0];
      endcase
   endtask

   // make up the next word of a mostly well-formed row stream
   function automatic req_word_type pick_word(bit allow_clear);
      req_word_type w;
      int r, ev;
      w.sval = nbct_pkg::SVAL_W'($urandom);
      w.cls  = nbct_pkg::CLS_W'($urandom);
      w.feat = nbct_pkg::FEAT_W'($urandom);
      w.qval = nbct_pkg::SVAL_W'($urandom);
      ev = eff_vals();
      r = $urandom_range(0, 99);
      if (allow_clear && r == 0) w.kind = nbct_pkg::KIND_CLEAR;
      else if (r < 72) begin
         w.kind = nbct_pkg::KIND_SAMPLE;
         if (row_pos == eff_cols() - 1) begin
            if ($urandom_range(0, 9) != 0 && eff_cls() > 0)
               w.sval = nbct_pkg::SVAL_W'($urandom_range(0, eff_cls() - 1));
         end else if ($urandom_range(0, 7) != 0 && ev > 0)
            w.sval = nbct_pkg::SVAL_W'((ev > 1023) ?
                        $urandom_range(0, 3) + 1020 * $urandom_range(0, 1) :
                        $urandom_range(0, (ev < 4) ? ev - 1 : 3));
      end else if (r < 82) begin
         w.kind = nbct_pkg::KIND_PRIOR;
      end else begin
         w.kind = nbct_pkg::KIND_COND;
         if ($urandom_range(0, 5) != 0) begin
            w.feat = nbct_pkg::FEAT_W'($urandom_range(0, eff_cols() - 2));
            w.qval = nbct_pkg::SVAL_W'((ev > 1023) ?
                        $urandom_range(0, 3) + 1020 * $urandom_range(0, 1) :
                        $urandom_range(0, 3));
            if (eff_cls() > 0) w.cls = nbct_pkg::CLS_W'($urandom_range(0, eff_cls() - 1));
         end
      end
      return w;
   endfunction

   // result stream checker
   always @(posedge clock) begin
      answer_type e;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         answers_seen++;
         if (answers_due.size() == 0) report("unexpected result", 1, 0);
         else begin
            e = answers_due.pop_front();
            if (rsp_if.probability !== e.prob) report("probability", rsp_if.probability, e.prob);
            if (rsp_if.raw_count !== e.raw) report("raw_count", rsp_if.raw_count, e.raw);
            if (rsp_if.status !== e.status) report("status", rsp_if.status, e.status);
         end
      end
   end

   // result receiver: random back-pressure plus one long hold
   initial begin
      rsp_if.ready = 0;
      forever begin
         @(negedge clock);
         if (hold_req) begin
            rsp_if.ready = 0;
            repeat (LONG_HOLD) @(negedge clock);
            hold_req = 0;
         end else if (!quiet && $urandom_range(0, 6) == 0) begin
            rsp_if.ready = 0;
            repeat ($urandom_range(1, 15) - 1) @(negedge clock);
         end else rsp_if.ready = 1;
      end
   end

   // stall watchdog
   always @(posedge clock) begin
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) ||
          (csr_psel && csr_penable)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCH_LIMIT) begin
         $display("watchdog expired, %0d answers outstanding", answers_due.size());
         $display("tb_naive_bayes_count_trainer: FAIL");
         $finish;
      end
   end

   initial begin
      dir_row_type tab [$];
      req_word_type w;
      answer_type a;
      int phase_cfg [7][3];
      bit cleared_once;

      req_if.valid = 0; req_if.kind = nbct_pkg::KIND_SAMPLE; req_if.sample_value = '0;
      req_if.class_index = '0; req_if.feature_index = '0; req_if.query_value = '0;
      cfg_cols = nbct_pkg::COLUMNS_RESET;
      cfg_cls  = nbct_pkg::CLASSES_RESET;
      cfg_vals = nbct_pkg::VALUES_RESET;
      wipe_model();
      repeat (6) @(negedge clock);
      reset = 0;

      // directed: three-column rows with the default class and value limits
      csr_write(nbct_pkg::CFG_COLUMNS, 3, 5);
      tab = '{
         '{nbct_pkg::KIND_PRIOR,  0,    0, 0, 0,    1, 0, 0, nbct_pkg::ST_EMPTY},
         '{nbct_pkg::KIND_PRIOR,  0,    7, 0, 0,    1, 0, 0, nbct_pkg::ST_EMPTY},
         '{nbct_pkg::KIND_COND,   0,    7, 1, 999,  1, 0, 0, nbct_pkg::ST_EMPTY},
         '{nbct_pkg::KIND_COND,   0,    0, 2, 0,    1, 0, 0, nbct_pkg::ST_RANGE},
         '{nbct_pkg::KIND_COND,   0,    0, 0, 1000, 1, 0, 0, nbct_pkg::ST_RANGE},
         '{nbct_pkg::KIND_SAMPLE, 5,    0, 0, 0,    0, 0, 0, nbct_pkg::ST_OK},
         '{nbct_pkg::KIND_SAMPLE, 1023, 0, 0, 0,    0, 0, 0, nbct_pkg::ST_OK},
         '{nbct_pkg::KIND_SAMPLE, 7,    0, 0, 0,    0, 0, 0, nbct_pkg::ST_OK},
         '{nbct_pkg::KIND_SAMPLE, 1,    0, 0, 0,    0, 0, 0, nbct_pkg::ST_OK},
         '{nbct_pkg::KIND_SAMPLE, 1,    0, 0, 0,    0, 0, 0, nbct_pkg::ST_OK},
         '{nbct_pkg::KIND_SAMPLE, 8,    0, 0, 0,    0, 0, 0, nbct_pkg::ST_OK},
         '{nbct_pkg::KIND_SAMPLE, 5,    0, 0, 0,    0, 0, 0, nbct_pkg::ST_OK},
         '{nbct_pkg::KIND_SAMPLE, 999,  0, 0, 0,    0, 0, 0, nbct_pkg::ST_OK},
         '{nbct_pkg::KIND_SAMPLE, 0,    0, 0, 0,    0, 0, 0, nbct_pkg::ST_OK},
         '{nbct_pkg::KIND_PRIOR,  0,    7, 0, 0,    1, 32768, 1, nbct_pkg::ST_OK},
         '{nbct_pkg::KIND_PRIOR,  0,    0, 0, 0,    0, 0, 0, nbct_pkg::ST_OK},
         '{nbct_pkg::KIND_COND,   0,    7, 0, 5,    1, 65536, 1, nbct_pkg::ST_OK},
         '{nbct_pkg::KIND_COND,   0,    7, 1, 1023, 1, 0, 0, nbct_pkg::ST_RANGE},
         '{nbct_pkg::KIND_COND,   0,    0, 1, 999,  0, 0, 0, nbct_pkg::ST_OK},
         '{nbct_pkg::KIND_COND,   0,    3, 0, 0,    1, 0, 0, nbct_pkg::ST_EMPTY},
         '{nbct_pkg::KIND_CLEAR,  0,    0, 0, 0,    0, 0, 0, nbct_pkg::ST_OK},
         '{nbct_pkg::KIND_PRIOR,  0,    0, 0, 0,    1, 0, 0, nbct_pkg::ST_EMPTY},
         '{nbct_pkg::KIND_COND,   0,    7, 0, 5,    1, 0, 0, nbct_pkg::ST_EMPTY}
      };
      foreach (tab[i]) begin
         w.kind = tab[i].kind;
         w.sval = nbct_pkg::SVAL_W'(tab[i].sval);
         w.cls  = nbct_pkg::CLS_W'(tab[i].cls);
         w.feat = nbct_pkg::FEAT_W'(tab[i].feat);
         w.qval = nbct_pkg::SVAL_W'(tab[i].qval);
         a.prob   = nbct_pkg::PROB_W'(tab[i].prob);
         a.raw    = nbct_pkg::RAW_W'(tab[i].raw);
         a.status = tab[i].status;
         send_word(w, tab[i].typed, a);
      end

      // random phases: columns, classes, values as written (clamping included)
      phase_cfg = '{'{2, 1, 1}, '{31, 15, 2047}, '{0, 0, 0}, '{5, 3, 7},
                    '{16, 8, 1024}, '{9, 5, 1024}, '{1, 2, 3}};
      cleared_once = 0;
      foreach (phase_cfg[p]) begin
         drain();
         csr_write(nbct_pkg::CFG_COLUMNS, phase_cfg[p][0], 5);
         csr_write(nbct_pkg::CFG_CLASSES, phase_cfg[p][1], 4);
         csr_write(nbct_pkg::CFG_VALUES,  phase_cfg[p][2], 11);
         phases_run++;
         quiet = (p == 6);
         if (p == 3) begin
            // hold the receiver off and keep offering queries to fill the block
            hold_req = 1;
            repeat (30) begin
               w = pick_word(0);
               w.kind = nbct_pkg::KIND_PRIOR;
               send_word(w);
            end
         end
         repeat (190) begin
            w = pick_word(!cleared_once && p == 4);
            if (w.kind == nbct_pkg::KIND_CLEAR) cleared_once = 1;
            send_word(w);
         end
      end
      drain();

      $display("sent %0d words over %0d register settings, checked %0d answers",
               words_sent, phases_run, answers_seen);
      if (errors == 0 && answers_due.size() == 0)
         $display("tb_naive_bayes_count_trainer: PASS");
      else
         $display("tb_naive_bayes_count_trainer: FAIL");
      $finish;
   end

endmodule
